[rtl/rpc_pkg.sv]
`default_nettype none
package rpc_pkg;
    localparam int COORD_BITS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int NUM_STAGES  = 4;
    localparam int IN_DEPTH    = 2;
    localparam int OUT_DEPTH   = 4;

    localparam int XMIN_RST = 0;
    localparam int XMAX_RST = 32767;
    localparam int YMIN_RST = 0;
    localparam int YMAX_RST = 32767;

    localparam logic [1:0] CFG_X_MIN = 2'd0;
    localparam logic [1:0] CFG_X_MAX = 2'd1;
    localparam logic [1:0] CFG_Y_MIN = 2'd2;
    localparam logic [1:0] CFG_Y_MAX = 2'd3;

    // vertex, polygon end, end of one input beat
    typedef enum logic [1:0] {
        TK_VERT = 2'd0,
        TK_END  = 2'd1,
        TK_STEP = 2'd2
    } t_tok_kind;

    typedef struct packed {
        logic      valid;
        t_tok_kind kind;
    } t_tok_ctl;

    typedef enum logic [2:0] {
        PH_E1_VERT  = 3'd0,
        PH_E1_CROSS = 3'd1,
        PH_E2_VERT  = 3'd2,
        PH_E2_CROSS = 3'd3,
        PH_FIRST    = 3'd4,
        PH_SECOND   = 3'd5,
        PH_CLOSE    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_MUL = 3'b010,
        ST_DIV = 3'b100
    } t_state;
endpackage
`default_nettype wire

[rtl/rect_polygon_clipper.sv]
`default_nettype none
// Clips a polygon, pushed one vertex a beat with last_vertex on its final vertex,
// against the rectangle in registers x_min, x_max, y_min, y_max (boundary counts as
// inside), through left, right, bottom and top stages. Results pop out in order;
// the final one carries out_last, and a polygon clipped away entirely gives one
// item with poly_empty set. A shared sequencer walks each token through the four
// stages depth first, phase by phase. A beat is two tokens, the vertex and an end
// marker. A vertex that fans out into several items takes longer, and every
// boundary crossing adds a multiply and a bit-serial divide. A full result queue
// stalls the sequencer. The input queue holds two vertices and the result queue
// four items.
module rect_polygon_clipper #(
    parameter int COORD_BITS = rpc_pkg::COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COORD_BITS-1:0] i_vert_x,
    input  logic [COORD_BITS-1:0] i_vert_y,
    input  logic                  i_last_vertex,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic                  o_out_last,
    output logic                  o_poly_empty,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data
);
    import rpc_pkg::*;

    logic [COORD_BITS-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    t_tok_ctl              f_tok, b_tok;
    logic [COORD_BITS-1:0] f_x, f_y, b_x, b_y;
    logic                  step_last, take, out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= COORD_BITS'(XMIN_RST);
            r_x_max <= COORD_BITS'(XMAX_RST);
            r_y_min <= COORD_BITS'(YMIN_RST);
            r_y_max <= COORD_BITS'(YMAX_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_MIN: r_x_min <= i_cfg_data;
                CFG_X_MAX: r_x_max <= i_cfg_data;
                CFG_Y_MIN: r_y_min <= i_cfg_data;
                CFG_Y_MAX: r_y_max <= i_cfg_data;
                default:   r_x_min <= r_x_min;
            endcase
        end
    end

    rpc_front #(
        .CW (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_vert_x      (i_vert_x),
        .i_vert_y      (i_vert_y),
        .i_last_vertex (i_last_vertex),
        .o_tok         (f_tok),
        .o_tok_x       (f_x),
        .o_tok_y       (f_y),
        .o_step_last   (step_last),
        .i_take        (take)
    );

    rpc_back #(
        .CW (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (f_tok),
        .i_tok_x     (f_x),
        .i_tok_y     (f_y),
        .o_take      (take),
        .i_x_min     (r_x_min),
        .i_x_max     (r_x_max),
        .i_y_min     (r_y_min),
        .i_y_max     (r_y_max),
        .o_tok       (b_tok),
        .o_tok_x     (b_x),
        .o_tok_y     (b_y),
        .i_out_ready (out_ready)
    );

    rpc_out #(
        .CW (COORD_BITS)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok        (b_tok),
        .i_tok_x      (b_x),
        .i_tok_y      (b_y),
        .i_step_last  (step_last),
        .o_ready      (out_ready),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_last   (o_out_last),
        .o_poly_empty (o_poly_empty)
    );
endmodule
`default_nettype wire

[rtl/rpc_front.sv]
`default_nettype none
module rpc_front #(
    parameter int CW = rpc_pkg::COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [CW-1:0]     i_vert_x,
    input  logic [CW-1:0]     i_vert_y,
    input  logic              i_last_vertex,
    output rpc_pkg::t_tok_ctl o_tok,
    output logic [CW-1:0]     o_tok_x,
    output logic [CW-1:0]     o_tok_y,
    output logic              o_step_last,
    input  logic              i_take
);
    import rpc_pkg::*;

    localparam int AW = $clog2(IN_DEPTH);

    logic [CW-1:0] r_qx [IN_DEPTH];
    logic [CW-1:0] r_qy [IN_DEPTH];
    logic          r_ql [IN_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          r_mark;
    logic          r_beat_last;
    logic          push_ok, pop_ok, take_ok;

    assign o_full      = (r_cnt == (AW+1)'(IN_DEPTH));
    assign push_ok     = i_push && !o_full;
    assign o_tok_x     = r_qx[r_rp];
    assign o_tok_y     = r_qy[r_rp];
    // last flag of the beat now being worked on by the back part
    assign o_step_last = r_beat_last;

    // each beat becomes a vertex token followed by a marker token
    always_comb begin
        o_tok.valid = (r_cnt != '0);
        if (!r_mark) begin
            o_tok.kind = TK_VERT;
        end else if (r_ql[r_rp]) begin
            o_tok.kind = TK_END;
        end else begin
            o_tok.kind = TK_STEP;
        end
        take_ok = i_take && o_tok.valid;
        pop_ok  = take_ok && r_mark;
        n_cnt   = r_cnt + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
            r_mark      <= 1'b0;
            r_beat_last <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push_ok) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + AW'(1);
            end
            if (take_ok) begin
                r_mark <= !r_mark;
            end
            if (take_ok && !r_mark) begin
                r_beat_last <= r_ql[r_rp];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_qx[r_wp] <= i_vert_x;
            r_qy[r_wp] <= i_vert_y;
            r_ql[r_wp] <= i_last_vertex;
        end
    end
endmodule
`default_nettype wire

[rtl/rpc_div.sv]
`default_nettype none
module rpc_div #(
    parameter int NW = 2 * rpc_pkg::COORD_BITS + 2,
    parameter int DW = rpc_pkg::COORD_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CTW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_d;
    logic [CTW-1:0] r_ctr;
    logic           r_run, r_done;
    logic [DW:0]    sh, diff;
    logic           ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        sh   = {r_rem, r_q[NW-1]};
        ge   = (sh >= {1'b0, r_d});
        diff = sh - {1'b0, r_d};
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ctr  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_ctr <= CTW'(NW);
            end else if (r_run) begin
                r_ctr <= r_ctr - CTW'(1);
                if (r_ctr == CTW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (r_run) begin
            r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end
endmodule
`default_nettype wire

[rtl/rpc_back.sv]
`default_nettype none
module rpc_back #(
    parameter int CW = rpc_pkg::COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpc_pkg::t_tok_ctl i_tok,
    input  logic [CW-1:0]     i_tok_x,
    input  logic [CW-1:0]     i_tok_y,
    output logic              o_take,
    input  logic [CW-1:0]     i_x_min,
    input  logic [CW-1:0]     i_x_max,
    input  logic [CW-1:0]     i_y_min,
    input  logic [CW-1:0]     i_y_max,
    output rpc_pkg::t_tok_ctl o_tok,
    output logic [CW-1:0]     o_tok_x,
    output logic [CW-1:0]     o_tok_y,
    input  logic              i_out_ready
);
    import rpc_pkg::*;

    localparam int LVLS    = NUM_STAGES + 1;
    localparam int OUT_LVL = NUM_STAGES;
    localparam int SW      = $clog2(NUM_STAGES);
    localparam int LW      = $clog2(LVLS);
    localparam int PW      = 2 * CW + 2;

    // token slot per level, level NUM_STAGES feeds the output side
    logic [LVLS-1:0] r_busy;
    t_tok_kind       r_tk [LVLS];
    logic [CW-1:0]   r_tx [LVLS];
    logic [CW-1:0]   r_ty [LVLS];
    t_phase          r_ph [NUM_STAGES];

    logic [CW-1:0]   r_fx [NUM_STAGES];
    logic [CW-1:0]   r_fy [NUM_STAGES];
    logic [CW-1:0]   r_sx [NUM_STAGES];
    logic [CW-1:0]   r_sy [NUM_STAGES];
    logic [CW-1:0]   r_px [NUM_STAGES];
    logic [CW-1:0]   r_py [NUM_STAGES];
    logic [1:0]      r_vc [NUM_STAGES];

    t_state          r_st;
    logic            r_div_go;
    logic [CW:0]     r_ma, r_mb, r_md;
    logic            r_neg, r_dz;
    logic [CW-1:0]   r_c, r_o1;
    logic [PW-1:0]   r_prod;

    logic            div_done;
    logic [PW-1:0]   div_quo;

    logic [SW-1:0]   cur;
    logic            any_stage;
    logic [LW-1:0]   nxt_lvl;
    t_tok_kind       k;
    logic [1:0]      vc;
    t_phase          ph;
    logic [CW-1:0]   vx, vy, p1x, p1y, q1x, q1y, epx, epy, eqx, eqy;
    logic            has_e1, has_e2, has_e, use2;
    logic signed [CW-1:0] pa, qa, po, qo, bc;
    logic            pin, qin;
    logic            emit, cross_go;
    t_tok_kind       emit_kind;
    logic [CW-1:0]   emit_x, emit_y;
    logic signed [CW:0] den, num, dro;
    logic [CW:0]     mq;
    logic signed [CW+1:0] o1e, res;
    logic [CW-1:0]   cross_x, cross_y;
    logic            do_out, do_stage, do_adv, do_close, do_cross, cross_done, push_child;
    t_tok_kind       child_kind;
    logic [CW-1:0]   child_x, child_y;

    rpc_div #(
        .NW (PW),
        .DW (CW + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_prod),
        .i_den   (r_md),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        cur = '0;
        for (int s = 0; s < NUM_STAGES; s++) begin
            if (r_busy[s]) begin
                cur = SW'(s);
            end
        end
        any_stage = |r_busy[NUM_STAGES-1:0];
        nxt_lvl   = LW'(cur) + LW'(1);

        k  = r_tk[cur];
        vc = r_vc[cur];
        ph = r_ph[cur];
        vx = r_tx[cur];
        vy = r_ty[cur];

        has_e2 = (k == TK_VERT) && (vc == 2'd2);
        has_e1 = ((k == TK_VERT) && vc[1]) || ((k == TK_END) && (vc == 2'd3));
        if (has_e2) begin
            p1x = r_fx[cur];
            p1y = r_fy[cur];
            q1x = r_sx[cur];
            q1y = r_sy[cur];
        end else begin
            p1x = r_px[cur];
            p1y = r_py[cur];
            q1x = (k == TK_VERT) ? vx : r_fx[cur];
            q1y = (k == TK_VERT) ? vy : r_fy[cur];
        end
        use2  = (ph == PH_E2_VERT) || (ph == PH_E2_CROSS);
        epx   = use2 ? r_sx[cur] : p1x;
        epy   = use2 ? r_sy[cur] : p1y;
        eqx   = use2 ? vx : q1x;
        eqy   = use2 ? vy : q1y;
        has_e = use2 ? has_e2 : has_e1;

        // stages 0 and 1 test x, stages 2 and 3 test y
        pa = signed'(cur[1] ? epy : epx);
        po = signed'(cur[1] ? epx : epy);
        qa = signed'(cur[1] ? eqy : eqx);
        qo = signed'(cur[1] ? eqx : eqy);
        case (cur)
            2'd0:    bc = signed'(i_x_min);
            2'd1:    bc = signed'(i_x_max);
            2'd2:    bc = signed'(i_y_min);
            default: bc = signed'(i_y_max);
        endcase
        pin = cur[0] ? (pa <= bc) : (pa >= bc);
        qin = cur[0] ? (qa <= bc) : (qa >= bc);

        den = (CW+1)'(qa) - (CW+1)'(pa);
        num = (CW+1)'(bc) - (CW+1)'(pa);
        dro = (CW+1)'(qo) - (CW+1)'(po);

        emit      = 1'b0;
        cross_go  = 1'b0;
        emit_kind = TK_VERT;
        emit_x    = epx;
        emit_y    = epy;
        case (ph)
            PH_E1_VERT, PH_E2_VERT: begin
                emit = has_e && pin;
            end
            PH_E1_CROSS, PH_E2_CROSS: begin
                cross_go = has_e && (pin != qin);
            end
            PH_FIRST: begin
                emit   = (k == TK_END) && ((vc == 2'd1) || (vc == 2'd2));
                emit_x = r_fx[cur];
                emit_y = r_fy[cur];
            end
            PH_SECOND: begin
                emit   = (k == TK_END) && (vc == 2'd2);
                emit_x = r_sx[cur];
                emit_y = r_sy[cur];
            end
            PH_CLOSE: begin
                emit      = (k != TK_VERT);
                emit_kind = k;
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // crossing: other coordinate moves from the start vertex by the quotient
        mq      = r_dz ? '0 : div_quo[CW:0];
        o1e     = (CW+2)'(signed'(r_o1));
        res     = r_neg ? (o1e - signed'({1'b0, mq})) : (o1e + signed'({1'b0, mq}));
        cross_x = cur[1] ? res[CW-1:0] : r_c;
        cross_y = cur[1] ? r_c : res[CW-1:0];

        do_out     = (r_st == ST_RUN) && r_busy[OUT_LVL] && i_out_ready;
        do_stage   = (r_st == ST_RUN) && !r_busy[OUT_LVL] && any_stage;
        do_cross   = do_stage && cross_go;
        do_adv     = do_stage && !cross_go;
        do_close   = do_adv && (ph == PH_CLOSE);
        cross_done = (r_st == ST_DIV) && div_done;
        push_child = (do_adv && emit) || cross_done;
        child_kind = cross_done ? TK_VERT : emit_kind;
        child_x    = cross_done ? cross_x : emit_x;
        child_y    = cross_done ? cross_y : emit_y;

        o_take = (r_st == ST_RUN) && (r_busy == '0) && i_tok.valid;
    end

    assign o_tok.valid = r_busy[OUT_LVL];
    assign o_tok.kind  = r_tk[OUT_LVL];
    assign o_tok_x     = r_tx[OUT_LVL];
    assign o_tok_y     = r_ty[OUT_LVL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= '0;
            r_st     <= ST_RUN;
            r_div_go <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_vc[s] <= 2'd0;
                r_ph[s] <= PH_E1_VERT;
            end
        end else begin
            r_div_go <= (r_st == ST_MUL);
            case (r_st)
                ST_RUN: begin
                    if (do_cross) begin
                        r_st <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_st <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_st <= ST_RUN;
                    end
                end
                default: begin
                    r_st <= ST_RUN;
                end
            endcase
            if (do_out) begin
                r_busy[OUT_LVL] <= 1'b0;
            end
            if (o_take) begin
                r_busy[0] <= 1'b1;
                r_ph[0]   <= PH_E1_VERT;
            end
            if (push_child) begin
                r_busy[nxt_lvl] <= 1'b1;
                if (cur != SW'(NUM_STAGES - 1)) begin
                    r_ph[cur + SW'(1)] <= PH_E1_VERT;
                end
            end
            if (do_adv || cross_done) begin
                r_ph[cur] <= t_phase'(ph + 3'd1);
            end
            if (do_close) begin
                r_busy[cur] <= 1'b0;
                if (k == TK_END) begin
                    r_vc[cur] <= 2'd0;
                end else if ((k == TK_VERT) && (vc != 2'd3)) begin
                    r_vc[cur] <= vc + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_tk[0] <= i_tok.kind;
            r_tx[0] <= i_tok_x;
            r_ty[0] <= i_tok_y;
        end
        if (push_child) begin
            r_tk[nxt_lvl] <= child_kind;
            r_tx[nxt_lvl] <= child_x;
            r_ty[nxt_lvl] <= child_y;
        end
        if (do_close && (k == TK_VERT)) begin
            case (vc)
                2'd0: begin
                    r_fx[cur] <= vx;
                    r_fy[cur] <= vy;
                end
                2'd1: begin
                    r_sx[cur] <= vx;
                    r_sy[cur] <= vy;
                end
                default: begin
                    r_px[cur] <= vx;
                    r_py[cur] <= vy;
                end
            endcase
        end
        if (do_cross) begin
            r_ma  <= dro[CW] ? unsigned'(-dro) : unsigned'(dro);
            r_mb  <= num[CW] ? unsigned'(-num) : unsigned'(num);
            r_md  <= den[CW] ? unsigned'(-den) : unsigned'(den);
            r_neg <= dro[CW] ^ num[CW] ^ den[CW];
            r_dz  <= (den == '0);
            r_c   <= bc;
            r_o1  <= po;
        end
        if (r_st == ST_MUL) begin
            r_prod <= PW'(r_ma) * PW'(r_mb);
        end
    end

`ifndef SYNTH
    a_out_idle_in_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_RUN) |-> !r_busy[OUT_LVL])
        else $error("output slot busy during crossing");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_st == ST_DIV))
        else $error("divider finished outside wait state");
    a_mul_then_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_MUL) |=> (r_st == ST_DIV) && r_div_go)
        else $error("divider not started after multiply");
`endif
endmodule
`default_nettype wire

[rtl/rpc_out.sv]
`default_nettype none
module rpc_out #(
    parameter int CW = rpc_pkg::COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpc_pkg::t_tok_ctl i_tok,
    input  logic [CW-1:0]     i_tok_x,
    input  logic [CW-1:0]     i_tok_y,
    input  logic              i_step_last,
    output logic              o_ready,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [CW-1:0]     o_out_x,
    output logic [CW-1:0]     o_out_y,
    output logic              o_out_last,
    output logic              o_poly_empty
);
    import rpc_pkg::*;

    localparam int AW = $clog2(OUT_DEPTH);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic [CW-1:0] r_fx [OUT_DEPTH];
    logic [CW-1:0] r_fy [OUT_DEPTH];
    logic          r_fl [OUT_DEPTH];
    logic          r_fe [OUT_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [CW-1:0] r_hx, r_hy;
    logic          r_hv;
    logic [NW-1:0] r_n, lim;
    logic          go, wr, rd;
    logic [CW-1:0] wx, wy;
    logic          wl, we;

    assign o_ready      = (r_cnt != (AW+1)'(OUT_DEPTH));
    assign o_empty      = (r_cnt == '0);
    assign o_out_x      = r_fx[r_rp];
    assign o_out_y      = r_fy[r_rp];
    assign o_out_last   = r_fl[r_rp];
    assign o_poly_empty = r_fe[r_rp];

    always_comb begin
        go  = i_tok.valid && o_ready;
        rd  = i_pop && !o_empty;
        // in a closing beat the last slot is kept for the item with out_last
        lim = i_step_last ? NW'(MAX_RESULTS - 1) : NW'(MAX_RESULTS);
        wr  = 1'b0;
        wx  = r_hx;
        wy  = r_hy;
        wl  = 1'b0;
        we  = 1'b0;
        case (i_tok.kind)
            TK_VERT: begin
                wr = go && r_hv && (r_n < lim);
            end
            TK_END: begin
                wr = go;
                wl = 1'b1;
                we = !r_hv;
                if (!r_hv) begin
                    wx = '0;
                    wy = '0;
                end
            end
            default: begin
                wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_hv  <= 1'b0;
            r_n   <= '0;
        end else begin
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
            if (wr) begin
                r_wp <= r_wp + AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + AW'(1);
            end
            if (go) begin
                case (i_tok.kind)
                    TK_VERT: begin
                        r_hv <= 1'b1;
                        if (wr) begin
                            r_n <= r_n + NW'(1);
                        end
                    end
                    TK_END: begin
                        r_hv <= 1'b0;
                        r_n  <= '0;
                    end
                    default: begin
                        r_n <= '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (i_tok.kind == TK_VERT)) begin
            r_hx <= i_tok_x;
            r_hy <= i_tok_y;
        end
        if (wr) begin
            r_fx[r_wp] <= wx;
            r_fy[r_wp] <= wy;
            r_fl[r_wp] <= wl;
            r_fe[r_wp] <= we;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(OUT_DEPTH))
        else $error("result queue overfilled");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_poly_empty) |-> o_out_last)
        else $error("empty polygon item without out_last");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_RESULTS))
        else $error("per-beat result count out of range");
`endif
endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import rpc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        longint x;
        longint y;
    } vtx_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } vin_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
        logic          empty;
    } vout_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    logic [CW-1:0] i_vert_x;
    logic [CW-1:0] i_vert_y;
    logic          i_last_vertex;
    logic          empty;
    logic          pop;
    logic [CW-1:0] o_out_x;
    logic [CW-1:0] o_out_y;
    logic          o_out_last;
    logic          o_poly_empty;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [CW-1:0] i_cfg_data;

    rect_polygon_clipper u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_vert_x(i_vert_x), .i_vert_y(i_vert_y), .i_last_vertex(i_last_vertex),
        .empty(empty), .pop(pop),
        .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_last(o_out_last), .o_poly_empty(o_poly_empty),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // clip window and per-stage state of the predictor
    longint win_lo_x, win_hi_x, win_lo_y, win_hi_y;
    vtx_t   st_first [NUM_STAGES];
    vtx_t   st_second[NUM_STAGES];
    vtx_t   st_prev  [NUM_STAGES];
    int     st_count [NUM_STAGES];
    vtx_t   held_vtx;
    bit     held_ok;

    vin_t   pending_verts[$];
    vout_t  clipped_expect[$];
    int     errors;
    int     polys_sent, verts_sent, results_seen, empties_seen;
    longint cycle;
    bit     acc_beat;
    int     tx_gap, rx_gap, rx_hold;

    function automatic longint sx(logic [CW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic bit in_window(int s, vtx_t p);
        case (s)
            0: return p.x >= win_lo_x;
            1: return p.x <= win_hi_x;
            2: return p.y >= win_lo_y;
            default: return p.y <= win_hi_y;
        endcase
    endfunction

    // other coordinate of a boundary crossing, quotient rounded toward zero
    function automatic longint cross_coord(longint a1, longint a2, longint o1, longint o2,
                                           longint c);
        longint den, num, dro, m;
        bit neg;
        den = a2 - a1;
        num = c - a1;
        dro = o2 - o1;
        if (den == 0) return o1;
        m = ((dro < 0 ? -dro : dro) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
        neg = (dro < 0) != ((num < 0) != (den < 0));
        return neg ? o1 - m : o1 + m;
    endfunction

    function automatic void clip_edge(int s, vtx_t p, vtx_t q, ref vtx_t o[$]);
        bit pin, qin;
        vtx_t r;
        pin = in_window(s, p);
        qin = in_window(s, q);
        if (pin) o = {o, p};
        if (pin != qin) begin
            if (s < 2) begin
                r.x = (s == 0) ? win_lo_x : win_hi_x;
                r.y = cross_coord(p.x, q.x, p.y, q.y, r.x);
            end else begin
                r.y = (s == 2) ? win_lo_y : win_hi_y;
                r.x = cross_coord(p.y, q.y, p.x, q.x, r.y);
            end
            o = {o, r};
        end
    endfunction

    function automatic void stage_vertex(int s, vtx_t v, ref vtx_t o[$]);
        case (st_count[s])
            0: begin st_first[s] = v; st_count[s] = 1; end
            1: begin st_second[s] = v; st_count[s] = 2; end
            2: begin
                clip_edge(s, st_first[s], st_second[s], o);
                clip_edge(s, st_second[s], v, o);
                st_prev[s] = v;
                st_count[s] = 3;
            end
            default: begin
                clip_edge(s, st_prev[s], v, o);
                st_prev[s] = v;
            end
        endcase
    endfunction

    function automatic void stage_close(int s, ref vtx_t o[$]);
        if (st_count[s] == 1 || st_count[s] == 2) o = {o, st_first[s]};
        if (st_count[s] == 2) o = {o, st_second[s]};
        if (st_count[s] == 3) clip_edge(s, st_prev[s], st_first[s], o);
        st_count[s] = 0;
    endfunction

    function automatic void predict_clip(vin_t vi);
        vtx_t  src[$];
        vtx_t  dst[$];
        vtx_t  v;
        vout_t res[$];
        vout_t r;
        v.x = sx(vi.x);
        v.y = sx(vi.y);
        src = {v};
        for (int s = 0; s < NUM_STAGES; s++) begin
            dst = {};
            foreach (src[i]) stage_vertex(s, src[i], dst);
            if (vi.last) stage_close(s, dst);
            src = dst;
        end
        foreach (src[i]) begin
            if (held_ok && res.size() < MAX_RESULTS) begin
                r = '{held_vtx.x[CW-1:0], held_vtx.y[CW-1:0], 1'b0, 1'b0};
                res = {res, r};
            end
            held_vtx = src[i];
            held_ok = 1;
        end
        if (vi.last) begin
            // closing item displaces the sixteenth when a step overflows
            while (res.size() >= MAX_RESULTS) void'(res.pop_back());
            if (held_ok) r = '{held_vtx.x[CW-1:0], held_vtx.y[CW-1:0], 1'b1, 1'b0};
            else r = '{'0, '0, 1'b1, 1'b1};
            res = {res, r};
            held_ok = 0;
        end
        clipped_expect = {clipped_expect, res};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 0;
        end else if (push && !acc_beat) begin
            push <= 1;
        end else if (tx_gap > 0) begin
            push <= 0;
            tx_gap <= tx_gap - 1;
        end else if (pending_verts.size() > 0) begin
            push <= 1;
            i_vert_x <= pending_verts[0].x;
            i_vert_y <= pending_verts[0].y;
            i_last_vertex <= pending_verts[0].last;
            tx_gap <= pick_gap();
        end else begin
            push <= 0;
        end
    end

    // receiver, with one long hold-off so the input side backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
        end else if (cycle == 4000) begin
            pop <= 0;
            rx_hold <= 2500;
        end else if (rx_hold > 0) begin
            pop <= 0;
            rx_hold <= rx_hold - 1;
        end else if (rx_gap > 0) begin
            pop <= 0;
            rx_gap <= rx_gap - 1;
        end else begin
            pop <= 1;
            rx_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        vout_t e;
        cycle <= cycle + 1;
        acc_beat = i_rst_n && push && !full;
        if (acc_beat) begin
            predict_clip(pending_verts[0]);
            void'(pending_verts.pop_front());
        end
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (o_poly_empty) empties_seen++;
            if (clipped_expect.size() == 0) begin
                $error("unexpected result beat x=%0h y=%0h", o_out_x, o_out_y);
                errors++;
            end else begin
                e = clipped_expect.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %0h got %0h", e.x, o_out_x); errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %0h got %0h", e.y, o_out_y); errors++;
                end
                if (o_out_last !== e.last) begin
                    $error("out_last expected %0b got %0b", e.last, o_out_last); errors++;
                end
                if (o_poly_empty !== e.empty) begin
                    $error("poly_empty expected %0b got %0b", e.empty, o_poly_empty);
                    errors++;
                end
            end
        end
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", clipped_expect.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_vert(longint x, longint y, bit last);
        vin_t v;
        v.x = x[CW-1:0];
        v.y = y[CW-1:0];
        v.last = last;
        pending_verts = {pending_verts, v};
        verts_sent++;
        if (last) polys_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CW-1:0];
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_X_MIN: win_lo_x = sx(val[CW-1:0]);
            CFG_X_MAX: win_hi_x = sx(val[CW-1:0]);
            CFG_Y_MIN: win_lo_y = sx(val[CW-1:0]);
            default:   win_hi_y = sx(val[CW-1:0]);
        endcase
    endtask

    task automatic set_window(longint x0, longint x1, longint y0, longint y1);
        write_reg(CFG_X_MIN, x0);
        write_reg(CFG_X_MAX, x1);
        write_reg(CFG_Y_MIN, y0);
        write_reg(CFG_Y_MAX, y1);
    endtask

    task automatic drain();
        while (pending_verts.size() > 0 || clipped_expect.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // random polygon: mostly near the window, sometimes anywhere
    task automatic rand_poly(longint cx, longint cy, longint span);
        int n;
        bit wide;
        n = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(7, 3);
        wide = ($urandom_range(5) == 0);
        for (int i = 0; i < n; i++) begin
            if (wide) add_vert($signed($urandom_range(65535, 0)) - 32768,
                               $signed($urandom_range(65535, 0)) - 32768, i == n - 1);
            else add_vert(cx + longint'($urandom_range(2 * span)) - span,
                          cy + longint'($urandom_range(2 * span)) - span, i == n - 1);
        end
    endtask

    task automatic rand_phase(int cnt, longint cx, longint cy, longint span);
        int goal;
        goal = verts_sent + cnt;
        while (verts_sent < goal) rand_poly(cx, cy, span);
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        push = 0; pop = 0;
        i_vert_x = '0; i_vert_y = '0; i_last_vertex = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_X_MIN; i_cfg_data = '0;
        cycle = 0; errors = 0; tx_gap = 0; rx_gap = 0; rx_hold = 0;
        polys_sent = 0; verts_sent = 0; results_seen = 0; empties_seen = 0;
        win_lo_x = XMIN_RST; win_hi_x = XMAX_RST; win_lo_y = YMIN_RST; win_hi_y = YMAX_RST;
        held_ok = 0; held_vtx = '{0, 0};
        for (int s = 0; s < NUM_STAGES; s++) begin
            st_count[s] = 0;
            st_first[s] = '{0, 0}; st_second[s] = '{0, 0}; st_prev[s] = '{0, 0};
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed, reset window: inside, clipped away, short polygons
        add_vert(10, 10, 0); add_vert(100, 10, 0); add_vert(50, 90, 1);
        add_vert(-10, -10, 0); add_vert(-100, -5, 0); add_vert(-50, -90, 1);
        add_vert(5, 5, 1);
        add_vert(-7, 3, 0); add_vert(9, -4, 1);
        add_vert(-32768, -32768, 0); add_vert(32767, -32768, 0);
        add_vert(32767, 32767, 0); add_vert(-32768, 32767, 1);
        drain();
        // small window: crossings on every side, vertices on the boundary
        set_window(-100, 100, -80, 80);
        add_vert(-300, 0, 0); add_vert(0, -250, 0); add_vert(300, 0, 0); add_vert(0, 250, 1);
        add_vert(-100, -80, 0); add_vert(100, -80, 0); add_vert(100, 80, 0);
        add_vert(-100, 80, 1);
        add_vert(-150, -10, 0); add_vert(150, 13, 0); add_vert(7, 200, 1);
        drain();
        rand_phase(40, 0, 0, 250);
        set_window(-32768, 32767, -32768, 32767);
        rand_phase(30, 0, 0, 32000);
        set_window(500, -500, -32768, 32767);  // inverted: all clipped away
        rand_phase(20, 0, 0, 1000);
        set_window(-32768, 32767, 200, -200);
        rand_phase(15, 0, 0, 1000);
        set_window(-1200, 3000, -2500, 1700);
        rand_phase(50, 900, -400, 4000);
        set_window(0, 5, -3, 3);
        rand_phase(20, 2, 0, 40);

        $display("polygons %0d, vertices %0d, clipped results %0d (%0d empty)",
                 polys_sent, verts_sent, results_seen, empties_seen);
        $display("windows: reset, small, full range, inverted on x and y, offset, tiny");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/rpc_pkg.sv
rtl/rpc_front.sv
rtl/rpc_div.sv
rtl/rpc_back.sv
rtl/rpc_out.sv
rtl/rect_polygon_clipper.sv
test/testbench.sv
